[design/box_blur_3x3_edge_aware_defines.svh]
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH

`ifndef SYNTHESIS

// whenever ante holds, cons must hold in the same cycle
`define BB3EA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// whenever ante holds, cons must hold in the next cycle
`define BB3EA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BB3EA_ASSERT_IMP(lbl, ante, cons, msg)

`define BB3EA_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[design/bb3ea_pkg.sv]
// ----------------------------------------------------------------------------
// bb3ea_pkg
// Shared types, widths, register codes and the divide table of the box blur.
// ----------------------------------------------------------------------------
package bb3ea_pkg;

    localparam int PIX_W       = 8;
    localparam int RGB_W       = 3 * PIX_W;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int COORD_W     = 10;
    localparam int SUM_W       = 12;   // nine 8-bit values
    localparam int CNT_W       = 4;    // up to nine neighbours
    localparam int NUM_W       = SUM_W + 1;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = NUM_W + RECIP_W;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(1024);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sum_t;

    // ceil(2^18 / (2*cnt)); only the neighbour counts that can occur
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

[design/bb3ea_ram.sv]
// ----------------------------------------------------------------------------
// bb3ea_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bb3ea_ram #(
    parameter int  WIDTH = bb3ea_pkg::RGB_W,
    parameter int  DEPTH = bb3ea_pkg::MAX_WIDTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/box_blur_3x3_edge_aware.sv]
// Path: a result passes the input register, the window and the sum register to the output register.
// Throughput: one pixel per cycle while each pixel causes at most one result and out_ready is
// not held low; a pixel that causes several results (row end, last row) holds the input until
// they are issued one at a time by the single result adder/divider path.
// Reset: counters at zero, window cleared, dimensions 1024x1024, line stores not cleared.
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// 3x3 box blur over a raster RGB stream, neighbourhood clipped to the image.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_aware_defines.svh"

module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH  = bb3ea_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3ea_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [bb3ea_pkg::PIX_W-1:0]      in_red,
    input  logic [bb3ea_pkg::PIX_W-1:0]      in_green,
    input  logic [bb3ea_pkg::PIX_W-1:0]      in_blue,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bb3ea_pkg::COORD_W-1:0]    out_row,
    output logic [bb3ea_pkg::COORD_W-1:0]    out_col,
    output logic [bb3ea_pkg::PIX_W-1:0]      out_red,
    output logic [bb3ea_pkg::PIX_W-1:0]      out_green,
    output logic [bb3ea_pkg::PIX_W-1:0]      out_blue,
    output logic                             last_of_run,
    output logic                             frame_done,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bb3ea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3ea_pkg::CFG_W-1:0]      cfg_value
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WX_W  = (bb3ea_pkg::CFG_W > COL_W + 1) ? bb3ea_pkg::CFG_W : COL_W + 1;
    localparam int HX_W  = (bb3ea_pkg::CFG_W > ROW_W + 1) ? bb3ea_pkg::CFG_W : ROW_W + 1;

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    logic [bb3ea_pkg::CFG_W-1:0] width_reg;
    logic [bb3ea_pkg::CFG_W-1:0] height_reg;
    logic                        cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bb3ea_pkg::DIM_RESET;
            height_reg <= bb3ea_pkg::DIM_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                bb3ea_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_value;
                bb3ea_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_value;
            endcase
        end
    end

    logic [WX_W-1:0] cfg_w_x;
    logic [HX_W-1:0] cfg_h_x;
    logic [WX_W-1:0] w_eff;
    logic [HX_W-1:0] h_eff;

    assign cfg_w_x = WX_W'(width_reg);
    assign cfg_h_x = HX_W'(height_reg);

    always_comb
    begin
        if (cfg_w_x == '0)
            w_eff = WX_W'(1);
        else if (cfg_w_x > WX_W'(MAX_WIDTH))
            w_eff = WX_W'(MAX_WIDTH);
        else
            w_eff = cfg_w_x;

        if (cfg_h_x == '0)
            h_eff = HX_W'(1);
        else if (cfg_h_x > HX_W'(MAX_HEIGHT))
            h_eff = HX_W'(MAX_HEIGHT);
        else
            h_eff = cfg_h_x;
    end

    // ------------------------------------------------------------------------
    // position counters and input register
    // ------------------------------------------------------------------------
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic                 in_fire;
    logic                 eor;
    logic                 last_row;
    logic [3:0]           mask_next;

    logic                 s1_valid_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [COL_W-1:0]     s1_col_reg;
    bb3ea_pkg::rgb_t      s1_px_reg;
    logic [3:0]           s1_mask_reg;
    logic                 s1_rge1_reg;
    logic                 s1_rge2_reg;
    logic                 s1_take;

    assign in_ready = !s1_valid_reg || s1_take;
    assign in_fire  = in_valid && in_ready;
    assign eor      = (WX_W'(col_reg) + WX_W'(1)) >= w_eff;
    assign last_row = (HX_W'(row_reg) + HX_W'(1)) >= h_eff;

    // bit 0: (r-1,c-1)  bit 1: (r-1,c)  bit 2: (r,c-1)  bit 3: (r,c)
    assign mask_next = {last_row && eor,
                        last_row && (col_reg != '0),
                        (row_reg != '0) && eor,
                        (row_reg != '0) && (col_reg != '0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                if (eor)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            else if (s1_take)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_row_reg  <= row_reg;
            s1_col_reg  <= col_reg;
            s1_px_reg   <= {in_red, in_green, in_blue};
            s1_mask_reg <= mask_next;
            s1_rge1_reg <= row_reg != '0;
            s1_rge2_reg <= row_reg > ROW_W'(1);
        end
    end

    // ------------------------------------------------------------------------
    // line stores: read on accept, write when the pixel enters the window
    // ------------------------------------------------------------------------
    bb3ea_pkg::rgb_t older_rd;
    bb3ea_pkg::rgb_t prior_rd;
    bb3ea_pkg::rgb_t up1_eff;
    bb3ea_pkg::rgb_t up2_eff;
    logic            byp_reg;
    bb3ea_pkg::rgb_t byp_prior_reg;
    bb3ea_pkg::rgb_t byp_older_reg;

    bb3ea_ram #(
        .WIDTH (bb3ea_pkg::RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_row_store (
        .clk   (clk),
        .we    (s1_take),
        .waddr (s1_col_reg),
        .wdata (up1_eff),
        .re    (in_fire),
        .raddr (col_reg),
        .rdata (older_rd)
    );

    bb3ea_ram #(
        .WIDTH (bb3ea_pkg::RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_prior_row_store (
        .clk   (clk),
        .we    (s1_take),
        .waddr (s1_col_reg),
        .wdata (s1_px_reg),
        .re    (in_fire),
        .raddr (col_reg),
        .rdata (prior_rd)
    );

    // forward the write that lands on the column being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            byp_reg <= s1_take && (s1_col_reg == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byp_prior_reg <= s1_px_reg;
            byp_older_reg <= up1_eff;
        end
    end

    assign up1_eff = byp_reg ? byp_prior_reg : prior_rd;
    assign up2_eff = byp_reg ? byp_older_reg : older_rd;

    // ------------------------------------------------------------------------
    // window and result sequencer
    // ------------------------------------------------------------------------
    bb3ea_pkg::rgb_t     win_reg [3][3];
    logic [3:0]          em_mask_reg;
    logic [ROW_W-1:0]    em_row_reg;
    logic [COL_W-1:0]    em_col_reg;
    logic                em_rge1_reg;
    logic                em_rge2_reg;
    logic                em_cge1_reg;
    logic                em_cge2_reg;
    logic                em_busy;
    logic                em_issue;
    logic [3:0]          em_sel;
    logic                em_last;
    logic                sm_free;

    assign em_busy  = em_mask_reg != 4'b0;
    assign em_sel   = em_mask_reg & (~em_mask_reg + 4'd1);
    assign em_last  = (em_mask_reg & ~em_sel) == 4'b0;
    assign em_issue = em_busy && sm_free;
    assign s1_take  = s1_valid_reg && (!em_busy || (em_issue && em_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_mask_reg <= 4'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (s1_take)
        begin
            em_mask_reg <= s1_mask_reg;
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= s1_rge2_reg ? up2_eff : '0;
            win_reg[1][2] <= s1_rge1_reg ? up1_eff : '0;
            win_reg[2][2] <= s1_px_reg;
        end
        else if (em_issue)
        begin
            em_mask_reg <= em_mask_reg & ~em_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            em_row_reg  <= s1_row_reg;
            em_col_reg  <= s1_col_reg;
            em_rge1_reg <= s1_rge1_reg;
            em_rge2_reg <= s1_rge2_reg;
            em_cge1_reg <= s1_col_reg != '0;
            em_cge2_reg <= s1_col_reg > COL_W'(1);
        end
    end

    // neighbourhood sum for the selected result
    logic                               rs2;
    logic                               cs2;
    logic [2:0]                         row_use;
    logic [2:0]                         col_use;
    bb3ea_pkg::sum_t                    sum_next;
    logic [bb3ea_pkg::CNT_W-1:0]        cnt_next;
    logic [ROW_W-1:0]                   orow_next;
    logic [COL_W-1:0]                   ocol_next;

    assign rs2     = em_sel[2] || em_sel[3];
    assign cs2     = em_sel[1] || em_sel[3];
    assign row_use = {1'b1, em_rge1_reg, !rs2 && em_rge2_reg};
    assign col_use = {1'b1, em_cge1_reg, !cs2 && em_cge2_reg};

    always_comb
    begin
        sum_next = '0;
        cnt_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (row_use[i] && col_use[j])
                begin
                    sum_next.red   = sum_next.red   + bb3ea_pkg::SUM_W'(win_reg[i][j].red);
                    sum_next.green = sum_next.green + bb3ea_pkg::SUM_W'(win_reg[i][j].green);
                    sum_next.blue  = sum_next.blue  + bb3ea_pkg::SUM_W'(win_reg[i][j].blue);
                    cnt_next       = cnt_next + bb3ea_pkg::CNT_W'(1);
                end
            end
        end
    end

    assign orow_next = rs2 ? em_row_reg : em_row_reg - ROW_W'(1);
    assign ocol_next = cs2 ? em_col_reg : em_col_reg - COL_W'(1);

    // ------------------------------------------------------------------------
    // sum register
    // ------------------------------------------------------------------------
    logic                               sm_valid_reg;
    bb3ea_pkg::sum_t                    sm_sum_reg;
    logic [bb3ea_pkg::CNT_W-1:0]        sm_count_reg;
    logic [bb3ea_pkg::COORD_W-1:0]      sm_row_reg;
    logic [bb3ea_pkg::COORD_W-1:0]      sm_col_reg;
    logic                               sm_last_reg;
    logic                               sm_done_reg;
    logic                               sm_advance;
    logic                               out_free;

    assign sm_advance = sm_valid_reg && out_free;
    assign sm_free    = !sm_valid_reg || sm_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_valid_reg <= 1'b0;
        end
        else if (sm_free)
        begin
            sm_valid_reg <= em_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_issue)
        begin
            sm_sum_reg   <= sum_next;
            sm_count_reg <= cnt_next;
            sm_row_reg   <= bb3ea_pkg::COORD_W'(orow_next);
            sm_col_reg   <= bb3ea_pkg::COORD_W'(ocol_next);
            sm_last_reg  <= em_last;
            sm_done_reg  <= em_sel[3];
        end
    end

    // ------------------------------------------------------------------------
    // rounded mean: (2*sum + n) / (2n) by reciprocal multiply, into output
    // ------------------------------------------------------------------------
    logic [bb3ea_pkg::RECIP_W-1:0] recip_m;
    logic [bb3ea_pkg::NUM_W-1:0]   num_r;
    logic [bb3ea_pkg::NUM_W-1:0]   num_g;
    logic [bb3ea_pkg::NUM_W-1:0]   num_b;
    logic [bb3ea_pkg::PROD_W-1:0]  prod_r;
    logic [bb3ea_pkg::PROD_W-1:0]  prod_g;
    logic [bb3ea_pkg::PROD_W-1:0]  prod_b;

    assign recip_m = bb3ea_pkg::recip(sm_count_reg);
    assign num_r   = {sm_sum_reg.red, 1'b0}   + bb3ea_pkg::NUM_W'(sm_count_reg);
    assign num_g   = {sm_sum_reg.green, 1'b0} + bb3ea_pkg::NUM_W'(sm_count_reg);
    assign num_b   = {sm_sum_reg.blue, 1'b0}  + bb3ea_pkg::NUM_W'(sm_count_reg);
    assign prod_r  = bb3ea_pkg::PROD_W'(num_r) * bb3ea_pkg::PROD_W'(recip_m);
    assign prod_g  = bb3ea_pkg::PROD_W'(num_g) * bb3ea_pkg::PROD_W'(recip_m);
    assign prod_b  = bb3ea_pkg::PROD_W'(num_b) * bb3ea_pkg::PROD_W'(recip_m);

    logic                               out_valid_reg;
    logic [bb3ea_pkg::COORD_W-1:0]      out_row_reg;
    logic [bb3ea_pkg::COORD_W-1:0]      out_col_reg;
    bb3ea_pkg::rgb_t                    out_px_reg;
    logic                               out_last_reg;
    logic                               out_done_reg;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= sm_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sm_advance)
        begin
            out_row_reg      <= sm_row_reg;
            out_col_reg      <= sm_col_reg;
            out_px_reg.red   <= prod_r[bb3ea_pkg::RECIP_SHIFT +: bb3ea_pkg::PIX_W];
            out_px_reg.green <= prod_g[bb3ea_pkg::RECIP_SHIFT +: bb3ea_pkg::PIX_W];
            out_px_reg.blue  <= prod_b[bb3ea_pkg::RECIP_SHIFT +: bb3ea_pkg::PIX_W];
            out_last_reg     <= sm_last_reg;
            out_done_reg     <= sm_done_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign out_red     = out_px_reg.red;
    assign out_green   = out_px_reg.green;
    assign out_blue    = out_px_reg.blue;
    assign last_of_run = out_last_reg;
    assign frame_done  = out_done_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    `BB3EA_ASSERT_IMP(a_done_is_last, out_valid_reg && out_done_reg, out_last_reg,
                      "frame_done beat without last_of_run")
    `BB3EA_ASSERT_IMP(a_take_drains, s1_take, (em_mask_reg & ~em_sel) == 4'b0,
                      "window advanced with results pending")
    `BB3EA_ASSERT_NXT(a_mask_shrinks, em_busy && !s1_take,
                      (em_mask_reg & ~$past(em_mask_reg)) == 4'b0,
                      "pending results grew without a new pixel")
    `BB3EA_ASSERT_IMP(a_count_range, sm_valid_reg,
                      (sm_count_reg != 4'd0) && (sm_count_reg <= 4'd9),
                      "neighbour count out of range")

endmodule
